### hdl/sbv_pkg.sv
// Package for the square beep voice: field widths, register defaults,
// opcode codes, queue item and divider request/response types.
// No dependencies.
package sbv_pkg;

    localparam int RATE_W     = 18;
    localparam int LVL_W      = 24;
    localparam int SLOPE_W    = 26;
    localparam int CNT_W      = 17;
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 24;
    localparam int SHIFT_OUT  = LVL_W - (SAMPLE_W - 1);

    localparam int PEAK_MS_DEF  = 20;
    localparam int TOTAL_MS_DEF = 200;
    localparam int MS_MAX       = 600;
    localparam int MS_W         = $clog2(MS_MAX + 1);
    localparam int MS_PER_S     = 1000;

    localparam int NUM_W = RATE_W + MS_W;
    localparam int DEN_W = CNT_W;

    // floor(x / MS_PER_S) as (x * RECIP_MS) >> RECIP_SH, exact for any NUM_W-bit x
    localparam int RECIP_SH = 38;
    localparam int RECIP_W  = 29;
    localparam int PROD_W   = NUM_W + RECIP_W;
    localparam int QUO_W    = PROD_W - RECIP_SH;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);
    localparam logic [RECIP_W-1:0] RECIP_MS = RECIP_FULL[RECIP_W-1:0];

    localparam logic [CNT_W-1:0]  TOTAL_MIN = CNT_W'(100);
    localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

    localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(44100);
    localparam logic [LVL_W-1:0]  PEAK_RST = LVL_W'(2516582);
    localparam logic [LVL_W-1:0]  LVL_MAX  = {LVL_W{1'b1}};

    localparam int CFG_AW  = 1;
    localparam int CFG_DW  = LVL_W;
    localparam logic [CFG_AW-1:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_PEAK_LEVEL  = 1'b1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic              opcode;
        logic [STEP_W-1:0] step;
    } sbv_item_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } sbv_div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } sbv_div_rsp_t;

endpackage

### hdl/sbv_front.sv
// Front end of the beep voice: takes input beats and holds them in a short
// queue for the back end. Depends on sbv_pkg.
module sbv_front import sbv_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // phase_step[23:0]
    input  logic              s_tuser,   // opcode
    output logic              q_valid,
    output sbv_item_t         q_item,
    input  logic              q_pop
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    sbv_item_t              entries_reg [QDEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]      count_reg, count_next;
    logic                   push, pop;

    assign s_tready = (count_reg != CNT_QW'(QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = entries_reg[rd_ptr_reg];
    assign push     = s_tvalid & s_tready;
    assign pop      = q_pop & q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= '{opcode: s_tuser, step: s_tdata};
        end
    end

endmodule

### hdl/sbv_div.sv
// Restoring divider, one quotient bit per cycle, for the envelope slopes.
// Depends on sbv_pkg.
module sbv_div import sbv_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  sbv_div_req_t  req,
    output sbv_div_rsp_t  rsp
);

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            iter_next = ITER_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

### hdl/sbv_core.sv
// Back end of the beep voice: configuration registers, envelope and phase
// state, length and slope sequencer, output register. Depends on sbv_pkg.
module sbv_core import sbv_pkg::*; #(
    parameter int PEAK_MS  = PEAK_MS_DEF,
    parameter int TOTAL_MS = TOTAL_MS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wdata,
    input  logic               q_valid,
    input  sbv_item_t          q_item,
    output logic               q_pop,
    output sbv_div_req_t       div_req,
    input  sbv_div_rsp_t       div_rsp,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata   // sample[15:0], envelope_level[39:16]
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL_TOT   = 3'd1;
    localparam logic [2:0] S_DIV_TOT   = 3'd2;
    localparam logic [2:0] S_MUL_ATK   = 3'd3;
    localparam logic [2:0] S_DIV_ATK   = 3'd4;
    localparam logic [2:0] S_DIV_SLOPE = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [RATE_W-1:0]   rate_reg;
    logic [LVL_W-1:0]    peak_reg;

    logic [LVL_W-1:0]    level_reg, level_next;
    logic [SLOPE_W-1:0]  slope_reg, slope_next;
    logic [LVL_W-1:0]    phase_reg, phase_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    seg_len_reg, seg_len_next;
    logic                run_start_reg, run_start_next;

    logic                div_start_reg, div_start_next;
    logic [NUM_W-1:0]    div_num_reg, div_num_next;
    logic [DEN_W-1:0]    div_den_reg, div_den_next;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic [LVL_W-1:0]    out_level_reg, out_level_next;

    logic                out_free, take;
    logic [SAMPLE_W-1:0] mag, sample_val;
    logic [LVL_W+2:0]    lvl_sum;
    logic [LVL_W:0]      phase_sum;
    logic [CNT_W-1:0]    atk_len, dec_len;
    logic [NUM_W-1:0]    quot;
    logic [PROD_W-1:0]   recip_prod;
    logic [QUO_W-1:0]    ms_quot;

    assign out_free = !out_valid_reg || m_tready;
    assign take     = (state_reg == S_IDLE) && q_valid
                      && ((q_item.opcode == OP_START) || out_free);
    assign q_pop    = take;
    assign quot     = div_rsp.quot;

    assign recip_prod = PROD_W'(div_num_reg) * PROD_W'(RECIP_MS);
    assign ms_quot    = recip_prod[RECIP_SH +: QUO_W];

    assign mag        = SAMPLE_W'(level_reg >> SHIFT_OUT);
    assign sample_val = neg_reg ? SAMPLE_W'(-mag) : mag;
    assign lvl_sum    = $signed({3'b000, level_reg}) + $signed({slope_reg[SLOPE_W-1], slope_reg});
    assign phase_sum  = {1'b0, phase_reg} + {1'b0, step_reg};

    assign atk_len = (ms_quot == '0) ? CNT_W'(1) : ms_quot[CNT_W-1:0];
    assign dec_len = (total_reg > atk_len) ? total_reg - atk_len : CNT_W'(1);

    always_comb begin
        state_next      = state_reg;
        level_next      = level_reg;
        slope_next      = slope_reg;
        phase_next      = phase_reg;
        step_next       = step_reg;
        neg_next        = neg_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        seg_len_next    = seg_len_reg;
        run_start_next  = run_start_reg;
        div_start_next  = 1'b0;
        div_num_next    = div_num_reg;
        div_den_next    = div_den_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_sample_next = out_sample_reg;
        out_level_next  = out_level_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    if (q_item.opcode == OP_START) begin
                        level_next     = '0;
                        neg_next       = 1'b0;
                        phase_next     = '0;
                        step_next      = q_item.step;
                        run_start_next = 1'b1;
                        state_next     = S_MUL_TOT;
                    end else begin
                        out_valid_next  = 1'b1;
                        out_sample_next = sample_val;
                        out_level_next  = level_reg;
                        if (count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                            if (lvl_sum[LVL_W+2]) begin
                                level_next = '0;
                            end else if (lvl_sum[LVL_W+1:LVL_W] != 2'b00) begin
                                level_next = LVL_MAX;
                            end else begin
                                level_next = lvl_sum[LVL_W-1:0];
                            end
                        end else begin
                            run_start_next = 1'b0;
                            state_next     = S_MUL_ATK;
                        end
                        if (phase_sum[LVL_W]) begin
                            neg_next = !neg_reg;
                        end
                        phase_next = phase_sum[LVL_W-1:0];
                    end
                end
            end
            S_MUL_TOT: begin
                div_num_next = NUM_W'(rate_reg) * NUM_W'(TOTAL_MS);
                state_next   = S_DIV_TOT;
            end
            S_DIV_TOT: begin
                if (ms_quot < QUO_W'(TOTAL_MIN)) begin
                    total_next = TOTAL_MIN;
                end else if (ms_quot > QUO_W'(CNT_MAX)) begin
                    total_next = CNT_MAX;
                end else begin
                    total_next = ms_quot[CNT_W-1:0];
                end
                state_next = S_MUL_ATK;
            end
            S_MUL_ATK: begin
                div_num_next = NUM_W'(rate_reg) * NUM_W'(PEAK_MS);
                state_next   = S_DIV_ATK;
            end
            S_DIV_ATK: begin
                div_start_next = 1'b1;
                if (run_start_reg) begin
                    seg_len_next = atk_len;
                    div_num_next = NUM_W'(peak_reg);
                    div_den_next = atk_len;
                end else begin
                    seg_len_next = dec_len;
                    div_num_next = NUM_W'(level_reg);
                    div_den_next = dec_len;
                end
                state_next = S_DIV_SLOPE;
            end
            S_DIV_SLOPE: begin
                if (div_rsp.done) begin
                    count_next = seg_len_reg;
                    if (run_start_reg) begin
                        slope_next = {2'b00, quot[LVL_W-1:0]};
                    end else begin
                        slope_next = SLOPE_W'(-{2'b00, quot[LVL_W-1:0]});
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rate_reg      <= RATE_RST;
            peak_reg      <= PEAK_RST;
            level_reg     <= '0;
            slope_reg     <= '0;
            phase_reg     <= '0;
            step_reg      <= '0;
            neg_reg       <= 1'b0;
            count_reg     <= '0;
            total_reg     <= TOTAL_MIN;
            run_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            slope_reg     <= slope_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            run_start_reg <= run_start_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_SAMPLE_RATE: rate_reg <= cfg_wdata[RATE_W-1:0];
                    CFG_PEAK_LEVEL:  peak_reg <= cfg_wdata[LVL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        seg_len_reg    <= seg_len_next;
        div_num_reg    <= div_num_next;
        div_den_reg    <= div_den_next;
        out_sample_reg <= out_sample_next;
        out_level_reg  <= out_level_next;
    end

    assign div_req.start = div_start_reg;
    assign div_req.num   = div_num_reg;
    assign div_req.den   = div_den_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_level_reg, out_sample_reg};

endmodule

### hdl/square_beep_voice_unit.sv
// Square beep voice, top level: input queue, envelope back end, divider.
// Depends on sbv_pkg, sbv_front, sbv_core, sbv_div.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------
//   s_       | in  | tuser = opcode, tdata = phase_step
//   m_       | out | tdata = sample, envelope_level
//   cfg_     | in  | write only: 0 sample_rate, 1 peak_level
//
// An ordinary tick is handled in S_IDLE alone. A start beat holds the back end
// through MUL_TOT, DIV_TOT, MUL_ATK, DIV_ATK and DIV_SLOPE, a tick that opens
// the decay through MUL_ATK, DIV_ATK and DIV_SLOPE: each length is a reciprocal
// multiply, each slope waits on the one-bit-per-cycle divider (NUM_W = 28 bits).
// A two-beat queue takes input while the back end works or m_ is stalled.
// Reset is synchronous, active low; it restores register defaults.
module square_beep_voice_unit import sbv_pkg::*; #(
    parameter int PEAK_MS  = PEAK_MS_DEF,
    parameter int TOTAL_MS = TOTAL_MS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // phase_step[23:0]
    input  logic               s_tuser,   // opcode
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata    // sample[15:0], envelope_level[39:16]
);

    logic          q_valid;
    logic          q_pop;
    sbv_item_t     q_item;
    sbv_div_req_t  div_req;
    sbv_div_rsp_t  div_rsp;

    sbv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    sbv_core #(
        .PEAK_MS  (PEAK_MS),
        .TOTAL_MS (TOTAL_MS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sbv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

endmodule
